// ----- design/tpps_pkg.sv -----
// Shared types, constants and helpers for the timed pin pattern sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tpps_pkg;

    // Default sizes, handed to the top level parameters
    localparam int SEQ_DEPTH_DEF = 16;
    localparam int PIN_COUNT_DEF = 26;

    // Fixed field widths of the request and result
    localparam int ACT_W   = 2;
    localparam int IDX_W   = 4;
    localparam int PAT_W   = 27;
    localparam int WAIT_W  = 32;
    localparam int TIME_W  = 64;
    localparam int S_TDATA_W = 64;  // index, pattern, wait = 63 bits, padded
    localparam int S_TUSER_W = ACT_W;

    // Action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    // One accepted request
    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [PAT_W-1:0]  entry_pattern;
        logic signed [WAIT_W-1:0] entry_wait;
    } item_t;

    // Status part of a result
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } res_info_t;

    // A wait of zero or below holds for one tick
    function automatic logic [WAIT_W-1:0] eff_wait(input logic [WAIT_W-1:0] w);
        logic [WAIT_W-1:0] r;
        r = w;
        if (w[WAIT_W-1] || (w == '0)) begin
            r = WAIT_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/tpps_in_stage.sv -----
// Input register of the sequencer: holds one request until the core takes it.
// Depends on tpps_pkg (item_t).
`timescale 1ns / 1ps
`default_nettype none

module tpps_in_stage
    import tpps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    // Free when empty or when the held request leaves this cycle
    assign in_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- design/tpps_core.sv -----
// Sequencer state, pattern/wait tables and the single-pass update per request.
// Depends on tpps_pkg (item_t, res_info_t, action codes, eff_wait).
`timescale 1ns / 1ps
`default_nettype none

module tpps_core
    import tpps_pkg::*;
#(
    parameter int SEQ_DEPTH = SEQ_DEPTH_DEF,
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [PIN_COUNT-1:0] cfg_wdata,
    input  wire logic                 fire,
    input  wire item_t                item,
    output logic [PIN_COUNT-1:0]      pin_levels,
    output res_info_t                 info
);

    localparam int SW = $clog2(SEQ_DEPTH + 1);
    localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int CW = (SW > IDX_W) ? SW : IDX_W;

    // Tables: patterns and waits are undefined until loaded
    logic [PIN_COUNT-1:0] pat_tab  [SEQ_DEPTH];
    logic [WAIT_W-1:0]    wait_tab [SEQ_DEPTH];
    logic [SEQ_DEPTH-1:0] used_reg, used_next;

    logic [PIN_COUNT-1:0] mask_reg;
    logic [PIN_COUNT-1:0] levels_reg, levels_next;
    logic [SW-1:0]        stage_reg, stage_next;
    logic [SW-1:0]        length_reg, length_next;
    logic [WAIT_W-1:0]    remain_reg, remain_next;
    logic                 running_reg, running_next;
    logic [TIME_W-1:0]    clock_reg, clock_next;
    logic [TIME_W-1:0]    started_reg, started_next;

    logic                 done_w;
    logic [TIME_W-1:0]    end_w;
    logic [CW-1:0]        idx_wide;
    logic                 ld_ok;
    logic [AW-1:0]        ld_addr;
    logic [SW-1:0]        stage_inc;
    logic [AW-1:0]        st_addr;
    logic [WAIT_W-1:0]    remain_dec;
    logic [SW-1:0]        high_len;
    logic [PIN_COUNT-1:0] new_pat;

    // Load address decode
    assign idx_wide = CW'(item.entry_index);
    assign ld_ok    = idx_wide < CW'(SEQ_DEPTH);
    assign ld_addr  = idx_wide[AW-1:0];

    assign stage_inc  = stage_reg + SW'(1);
    assign st_addr    = stage_inc[AW-1:0];
    assign remain_dec = (remain_reg != '0) ? (remain_reg - WAIT_W'(1)) : '0;
    assign new_pat    = PIN_COUNT'(item.entry_pattern[PAT_W-2:0]);

    // Length on start: one past the highest used entry
    always_comb begin
        high_len = '0;
        for (int i = 0; i < SEQ_DEPTH; i++) begin
            if (used_reg[i]) begin
                high_len = SW'(i + 1);
            end
        end
    end

    // Next state for one request
    always_comb begin
        used_next    = used_reg;
        levels_next  = levels_reg;
        stage_next   = stage_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        running_next = running_reg;
        clock_next   = clock_reg;
        started_next = started_reg;
        done_w       = 1'b0;
        end_w        = '0;
        case (item.action)
            ACT_LOAD: begin
                if (ld_ok) begin
                    used_next[ld_addr] = !item.entry_pattern[PAT_W-1];
                end
            end
            ACT_START: begin
                length_next  = high_len;
                started_next = clock_reg;
                stage_next   = '0;
                if (used_reg[0]) begin
                    levels_next = (levels_reg & ~mask_reg) | (pat_tab[0] & mask_reg);
                end
                remain_next  = eff_wait(wait_tab[0]);
                running_next = 1'b1;
            end
            ACT_TICK: begin
                clock_next = clock_reg + TIME_W'(1);
                if (running_reg) begin
                    remain_next = remain_dec;
                    if (remain_dec == '0) begin
                        stage_next = stage_inc;
                        if ((stage_inc >= length_reg) || (stage_inc >= SW'(SEQ_DEPTH))) begin
                            running_next = 1'b0;
                            done_w       = 1'b1;
                            end_w        = clock_next;
                        end else begin
                            // unused middle entry drives all masked pins high
                            levels_next = (levels_reg & ~mask_reg) |
                                          ((used_reg[st_addr] ? pat_tab[st_addr] : '1)
                                           & mask_reg);
                            remain_next = eff_wait(wait_tab[st_addr]);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            mask_reg    <= '0;
            levels_reg  <= '0;
            stage_reg   <= '0;
            length_reg  <= '0;
            remain_reg  <= '0;
            running_reg <= 1'b0;
            clock_reg   <= '0;
            started_reg <= '0;
        end else begin
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
            if (fire) begin
                used_reg    <= used_next;
                levels_reg  <= levels_next;
                stage_reg   <= stage_next;
                length_reg  <= length_next;
                remain_reg  <= remain_next;
                running_reg <= running_next;
                clock_reg   <= clock_next;
                started_reg <= started_next;
            end
        end
    end

    // Table writes
    always_ff @(posedge aclk) begin
        if (fire && (item.action == ACT_LOAD) && ld_ok) begin
            pat_tab[ld_addr]  <= new_pat;
            wait_tab[ld_addr] <= item.entry_wait;
        end
    end

    // Result of this request, registered in the output stage
    assign pin_levels      = levels_next;
    assign info.busy       = running_next;
    assign info.done       = done_w;
    assign info.start_time = started_next;
    assign info.end_time   = end_w;

    // A running sequence always has a wait armed and a stage in the table
    a_remain_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (remain_reg != '0))
        else $error("running with no wait armed");

    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (stage_reg < SW'(SEQ_DEPTH)))
        else $error("stage beyond table while running");

    a_tick_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (item.action == ACT_TICK)) |=> (clock_reg == $past(clock_reg) + TIME_W'(1)))
        else $error("tick did not advance the clock by one");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && done_w) |=> (!running_reg && (clock_reg == $past(end_w))))
        else $error("done without stopping at the reported end time");

endmodule

`default_nettype wire

// ----- design/tpps_out_stage.sv -----
// Result register of the sequencer: holds one result until the sink takes it.
// Depends on tpps_pkg (res_info_t).
`timescale 1ns / 1ps
`default_nettype none

module tpps_out_stage
    import tpps_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire logic [PIN_COUNT-1:0] pins_in,
    input  wire res_info_t            info_in,
    output logic                      load_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [PIN_COUNT-1:0]      pins_out,
    output res_info_t                 info_out
);

    logic                 valid_reg, valid_next;
    logic [PIN_COUNT-1:0] pins_reg;
    res_info_t            info_reg;

    // Room for a new result when empty or when the held one leaves now
    assign load_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pins_reg <= pins_in;
            info_reg <= info_in;
        end
    end

    assign out_valid = valid_reg;
    assign pins_out  = pins_reg;
    assign info_out  = info_reg;

endmodule

`default_nettype wire

// ----- design/timed_pin_pattern_sequencer.sv -----
// Top level of the timed pin pattern sequencer: stream ports, packing, stages.
// Depends on tpps_pkg, tpps_in_stage, tpps_core, tpps_out_stage.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser action, tdata index/pattern/wait
//  m_       | out | m_tvalid/m_tready  | tdata levels/busy/done/start/end
//  cfg_     | in  | cfg_we             | cfg_wdata = pin_mask
//
// Every request yields exactly one result, through the input register and the result register.
// One request per cycle is sustained while m_tready is high; the state update is a single pass
// between the input register and the result register.
// Reset (aresetn low, synchronous) clears all state but the table contents and the stage payload registers.
// A stall on m_ backs up into s_tready after the two stages fill.
`timescale 1ns / 1ps
`default_nettype none

module timed_pin_pattern_sequencer
    import tpps_pkg::*;
#(
    parameter int SEQ_DEPTH = SEQ_DEPTH_DEF,
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [PIN_COUNT-1:0] cfg_wdata,   // pin_mask
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,     // entry_index, entry_pattern, entry_wait
    input  wire logic [S_TUSER_W-1:0] s_tuser,     // action
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [((PIN_COUNT + 2 + 2 * TIME_W + 7) / 8) * 8 - 1:0]
                                      m_tdata      // pin_levels, busy_res, seq_done,
                                                   // start_time, end_time
);

    localparam int M_TDATA_W = ((PIN_COUNT + 2 + 2 * TIME_W + 7) / 8) * 8;

    item_t                s_item;
    item_t                item;
    logic                 item_valid;
    logic                 load_ready;
    logic                 fire;
    logic [PIN_COUNT-1:0] core_pins;
    res_info_t            core_info;
    logic [PIN_COUNT-1:0] out_pins;
    res_info_t            out_info;

    // Unpack the request
    assign s_item.action        = s_tuser;
    assign s_item.entry_index   = s_tdata[IDX_W-1:0];
    assign s_item.entry_pattern = s_tdata[IDX_W+PAT_W-1:IDX_W];
    assign s_item.entry_wait    = s_tdata[IDX_W+PAT_W+WAIT_W-1:IDX_W+PAT_W];

    // Request moves into the core when the result register has room
    assign fire = item_valid && load_ready;

    tpps_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    tpps_core #(
        .SEQ_DEPTH (SEQ_DEPTH),
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fire       (fire),
        .item       (item),
        .pin_levels (core_pins),
        .info       (core_info)
    );

    tpps_out_stage #(
        .PIN_COUNT (PIN_COUNT)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .pins_in    (core_pins),
        .info_in    (core_info),
        .load_ready (load_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .pins_out   (out_pins),
        .info_out   (out_info)
    );

    // Pack the result, pin levels in the low bits
    assign m_tdata = M_TDATA_W'({out_info.end_time, out_info.start_time,
                                 out_info.done, out_info.busy, out_pins});

endmodule

`default_nettype wire

// ----- tb/tb_timed_pin_pattern_sequencer.sv -----
// Self-checking testbench for timed_pin_pattern_sequencer: directed table, then
// random load/start/tick sequences under random stalls, checked by a local predictor.
// Depends on tpps_pkg and the timed_pin_pattern_sequencer RTL.
`timescale 1ns / 1ps

module tb_timed_pin_pattern_sequencer;
    import tpps_pkg::*;

    localparam int          DEPTH       = 16;
    localparam int          PINS        = 26;
    localparam int          M_W         = ((PINS + 2 + 2 * TIME_W + 7) / 8) * 8;
    localparam int          LIMIT       = 200000;
    localparam int          MAX_TICKS   = 80;
    localparam logic [1:0]  ACT_NOP     = 2'd3;
    localparam logic [26:0] PAT_UNUSED  = 27'h7FFFFFF;
    localparam logic [25:0] ALL_PINS    = 26'h3FFFFFF;

    // one request as the block sees it
    typedef struct packed {
        logic [1:0]  act;
        logic [3:0]  idx;
        logic [26:0] pat;
        logic [31:0] hold;
    } req_t;

    // one result, in m_tdata field order
    typedef struct packed {
        logic [25:0] levels;
        logic        busy;
        logic        done;
        logic [63:0] start_time;
        logic [63:0] end_time;
    } result_t;

    // directed row: request plus an optional hand-written result
    typedef struct packed {
        req_t    rq;
        logic    typed;
        result_t res;
    } plan_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [PINS-1:0]    cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [M_W-1:0]     m_tdata;

    timed_pin_pattern_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state
    logic [25:0] tbl_pat  [DEPTH];
    logic        tbl_used [DEPTH];
    logic [31:0] tbl_hold [DEPTH];
    int          stage_now;
    int          seq_len;
    logic [31:0] hold_left;
    logic        seq_active;
    logic [25:0] pin_state;
    logic [63:0] usec_now;
    logic [63:0] seq_started;
    logic [25:0] mask_now;

    result_t     expected_outputs[$];
    int          errors = 0;
    int          cycles = 0;
    int          accepted_count;
    int          gap_ahead;
    bit          valid_held;
    bit          s_calm;
    bit          m_calm;
    plan_row_t   plan [0:20];

    // clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // zero or negative wait holds for one tick
    function automatic logic [31:0] hold_ticks(input logic [31:0] w);
        return (w[31] || w == '0) ? 32'd1 : w;
    endfunction

    function automatic void drive_pins(input logic [25:0] p);
        pin_state = (pin_state & ~mask_now) | (p & mask_now);
    endfunction

    // advance the predictor by one request and return the result it causes
    function automatic result_t next_pin_result(input req_t r);
        result_t res;
        res = '0;
        case (r.act)
            ACT_LOAD: begin
                tbl_used[r.idx] = !r.pat[26];
                tbl_pat[r.idx]  = r.pat[26] ? ALL_PINS : r.pat[25:0];
                tbl_hold[r.idx] = r.hold;
            end
            ACT_START: begin
                seq_len = 0;
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_used[i]) seq_len = i + 1;
                seq_started = usec_now;
                stage_now   = 0;
                if (tbl_used[0]) drive_pins(tbl_pat[0]);
                hold_left  = hold_ticks(tbl_hold[0]);
                seq_active = 1'b1;
            end
            ACT_TICK: begin
                usec_now = usec_now + 64'd1;
                if (seq_active) begin
                    if (hold_left != 0) hold_left = hold_left - 32'd1;
                    if (hold_left == 0) begin
                        stage_now = stage_now + 1;
                        if (stage_now >= seq_len || stage_now >= DEPTH) begin
                            seq_active   = 1'b0;
                            res.done     = 1'b1;
                            res.end_time = usec_now;
                        end else begin
                            // an unused middle stage drives all masked pins high
                            drive_pins(tbl_used[4'(stage_now)] ? tbl_pat[4'(stage_now)]
                                                               : ALL_PINS);
                            hold_left = hold_ticks(tbl_hold[4'(stage_now)]);
                        end
                    end
                end
            end
            default: ;
        endcase
        res.levels     = pin_state;
        res.busy       = seq_active;
        res.start_time = seq_started;
        return res;
    endfunction

    function automatic logic [26:0] rand_pattern();
        logic [26:0] p;
        p = 27'($urandom());
        case ($urandom_range(0, 9))
            0: p = PAT_UNUSED;
            1: p[26] = 1'b1;
            2: p = '0;
            3: p = {1'b0, ALL_PINS};
            default: p[26] = 1'b0;
        endcase
        return p;
    endfunction

    // mostly short waits; now and then a negative or a very long one
    function automatic logic [31:0] rand_hold();
        logic [31:0] h;
        h = $urandom();
        case ($urandom_range(0, 19))
            0: h = '0;
            1: h = '1;
            2: h[31] = 1'b1;
            3: h[31] = 1'b0;
            default: h = $urandom_range(1, 4);
        endcase
        return h;
    endfunction

    function automatic req_t fill_req(input logic [1:0] act);
        req_t r;
        r.act  = act;
        r.idx  = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 5));
        r.pat  = rand_pattern();
        r.hold = rand_hold();
        return r;
    endfunction

    // drop tvalid if it was left high for a back-to-back request
    task automatic release_bus();
        if (valid_held) begin
            s_tvalid   <= 1'b0;
            valid_held  = 1'b0;
        end
    endtask

    // send one request, then predict its result
    task automatic send_req(input req_t r, input logic typed, input result_t fixed);
        result_t res;
        repeat (gap_ahead) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.act;
        s_tdata  <= {1'b0, r.hold, r.pat, r.idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = next_pin_result(r);
        expected_outputs.push_back(typed ? fixed : res);
        accepted_count++;
        if ($urandom_range(0, 15) == 0) s_calm = !s_calm;
        gap_ahead = s_calm ? 0 : $urandom_range(0, 9);
        if (gap_ahead > 0) begin
            s_tvalid   <= 1'b0;
            valid_held  = 1'b0;
        end else begin
            valid_held = 1'b1;
        end
    endtask

    // mask changes only with nothing in flight
    task automatic set_pin_mask(input logic [25:0] v);
        release_bus();
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mask_now   = v;
    endtask

    // random traffic: mostly load, start and tick to the end, some noise
    task automatic run_random(input int target);
        int ticks;
        while (accepted_count < target) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, 4)) send_req(fill_req(ACT_LOAD), 1'b0, '0);
                send_req(fill_req(ACT_START), 1'b0, '0);
                ticks = 0;
                while (seq_active && ticks < MAX_TICKS && accepted_count < target) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_req(fill_req(2'($urandom_range(0, 3))), 1'b0, '0);
                    end else begin
                        send_req(fill_req(ACT_TICK), 1'b0, '0);
                        ticks++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 5))
                    send_req(fill_req(2'($urandom_range(0, 3))), 1'b0, '0);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
            end else begin
                want = expected_outputs.pop_front();
                check_field("pin_levels", 64'(want.levels), 64'(m_tdata[25:0]));
                check_field("busy_res", 64'(want.busy), 64'(m_tdata[26]));
                check_field("seq_done", 64'(want.done), 64'(m_tdata[27]));
                check_field("start_time", want.start_time, m_tdata[91:28]);
                check_field("end_time", want.end_time, m_tdata[155:92]);
            end
        end
    end

    // result side stalls
    initial begin
        int gap;
        m_tready = 1'b0;
        m_calm   = 1'b0;
        forever begin
            if ($urandom_range(0, 15) == 0) m_calm = !m_calm;
            gap = m_calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // stimulus
    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        accepted_count = 0;
        gap_ahead      = 0;
        valid_held     = 1'b0;
        s_calm         = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_used[i] = 1'b0;
            tbl_pat[i]  = '0;
            tbl_hold[i] = '0;
        end
        stage_now   = 0;
        seq_len     = 0;
        hold_left   = '0;
        seq_active  = 1'b0;
        pin_state   = '0;
        usec_now    = '0;
        seq_started = '0;
        mask_now    = '0;

        //            act        idx    pattern        wait           typed levels busy done start end
        // tick and reserved code while idle, empty sequence, then the all-high entry 0
        plan[0]  = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b1,
                     '{26'd0, 1'b0, 1'b0, 64'd0, 64'd0}};
        plan[1]  = '{'{ACT_NOP,   4'd0,  27'd0,         32'd0},        1'b1,
                     '{26'd0, 1'b0, 1'b0, 64'd0, 64'd0}};
        plan[2]  = '{'{ACT_LOAD,  4'd0,  PAT_UNUSED,    32'd0},        1'b1,
                     '{26'd0, 1'b0, 1'b0, 64'd0, 64'd0}};
        plan[3]  = '{'{ACT_START, 4'd0,  27'd0,         32'd0},        1'b1,
                     '{26'd0, 1'b1, 1'b0, 64'd1, 64'd0}};
        plan[4]  = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b1,
                     '{26'd0, 1'b0, 1'b1, 64'd1, 64'd2}};
        plan[5]  = '{'{ACT_LOAD,  4'd0,  27'h3FFFFFF,   32'hFFFFFFFF}, 1'b1,
                     '{26'd0, 1'b0, 1'b0, 64'd1, 64'd0}};
        // unused middle, most negative wait, negative pattern that is not -1, longest wait
        plan[6]  = '{'{ACT_LOAD,  4'd1,  PAT_UNUSED,    32'd2},        1'b0, '0};
        plan[7]  = '{'{ACT_LOAD,  4'd2,  27'd0,         32'h80000000}, 1'b0, '0};
        plan[8]  = '{'{ACT_LOAD,  4'd3,  27'h4000000,   32'd1},        1'b0, '0};
        plan[9]  = '{'{ACT_LOAD,  4'd4,  27'h1555555,   32'h7FFFFFFF}, 1'b0, '0};
        plan[10] = '{'{ACT_START, 4'd0,  27'd0,         32'd0},        1'b0, '0};
        plan[11] = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b0, '0};
        // load while running
        plan[12] = '{'{ACT_LOAD,  4'd5,  27'h2AAAAAA,   32'd3},        1'b0, '0};
        plan[13] = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b0, '0};
        plan[14] = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b0, '0};
        plan[15] = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b0, '0};
        plan[16] = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b0, '0};
        plan[17] = '{'{ACT_TICK,  4'd0,  27'd0,         32'd0},        1'b0, '0};
        // restart while running, then extremes on a loaded and an ignored request
        plan[18] = '{'{ACT_START, 4'd0,  27'd0,         32'd0},        1'b0, '0};
        plan[19] = '{'{ACT_LOAD,  4'd15, 27'd0,         32'h7FFFFFFF}, 1'b0, '0};
        plan[20] = '{'{ACT_NOP,   4'd15, PAT_UNUSED,    32'hFFFFFFFF}, 1'b0, '0};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, all pins driven
        set_pin_mask(ALL_PINS);
        foreach (plan[i]) send_req(plan[i].rq, plan[i].typed, plan[i].res);

        // random part: write every entry first so no stage reads an empty slot
        set_pin_mask('0);
        for (int i = 0; i < DEPTH; i++) begin
            req_t r;
            r     = fill_req(ACT_LOAD);
            r.idx = 4'(i);
            send_req(r, 1'b0, '0);
        end
        run_random(accepted_count + 100);
        set_pin_mask(26'($urandom()));
        run_random(accepted_count + 100);
        set_pin_mask(ALL_PINS);
        run_random(accepted_count + 100);
        set_pin_mask(26'($urandom()));
        run_random(accepted_count + 100);

        // drain and report
        release_bus();
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
